[src/ufcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_pkg
// Shared types and constants for the union-find cycle detector.
// ----------------------------------------------------------------------------
package ufcd_pkg;

    localparam int VERTEX_W         = 10;
    localparam int SHIFT_W          = 4;
    localparam int MAX_VERTICES_DEF = 1024;

    typedef struct packed {
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
    } ufcd_edge_t;

    typedef struct packed {
        logic                closes_cycle;
        logic                cycle_seen;
        logic [VERTEX_W-1:0] from_root;
        logic [VERTEX_W-1:0] to_root;
    } ufcd_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_START,
        ST_FIND_A,
        ST_FIND_B,
        ST_DONE
    } ufcd_state_t;

endpackage

[src/ufcd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ufcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/union_find_cycle_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_detector_unit
// Walks both endpoints of each edge to their roots in a parent table held in
// RAM, flags a cycle when the roots match and links the roots otherwise.
// ----------------------------------------------------------------------------
//  channel | ports                    | word
//  --------+--------------------------+-------------------------------------
//  edge in | s_valid s_ready s_data   | from_vertex, to_vertex
//  result  | m_valid m_ready m_data   | closes_cycle, cycle_seen, roots
//
//  Each edge walks the parent chains of both endpoints, first from_vertex,
//  then to_vertex; each chain step is one read of the parent RAM.
//  Before the walks the endpoints are reduced: 0 steps when MAX_VERTICES is
//  a power of two or at least 1024, else 11 - clog2(MAX_VERTICES) steps of
//  shift-subtract. After reset a clearing pass marks every entry as a root,
//  with s_ready low. A result waiting on m_ready holds the finish step; the
//  next edge is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module union_find_cycle_detector_unit #(
    parameter int MAX_VERTICES = ufcd_pkg::MAX_VERTICES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ufcd_pkg::ufcd_edge_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ufcd_pkg::ufcd_result_t m_data
);

    import ufcd_pkg::*;

    localparam int  VW        = $clog2(MAX_VERTICES);
    localparam bit  IS_POW2   = ((1 << VW) == MAX_VERTICES);
    localparam int  RED_STEPS = (MAX_VERTICES >= 1024 || IS_POW2) ? 0 : 11 - VW;
    localparam int  MOD_W     = VERTEX_W + 1;
    localparam logic [MOD_W-1:0]   MOD_C   = MOD_W'(MAX_VERTICES);
    localparam logic [VW-1:0]      LAST    = VW'(MAX_VERTICES - 1);
    localparam logic [SHIFT_W-1:0] K_FIRST = SHIFT_W'(RED_STEPS - 1);

    ufcd_state_t state_reg, state_next;

    logic [VERTEX_W-1:0] a_reg, b_reg;
    logic [VW-1:0]       cur_reg, root_a_reg;
    logic [VW-1:0]       clr_reg;
    logic [SHIFT_W-1:0]  k_reg;
    logic                cycle_reg;
    logic                m_valid_reg;
    ufcd_result_t        m_data_reg;

    // RAM ports
    logic          ram_we;
    logic [VW-1:0] ram_waddr, ram_raddr;
    logic [VW:0]   ram_wdata, ram_rdata;
    logic          rd_root;
    logic [VW-1:0] rd_parent;

    logic done_go;
    logic closes;

    // endpoint index mapping and reduction
    logic [VW+VERTEX_W-1:0] a_ext, b_ext, ra_ext, rb_ext;
    logic [VW-1:0]          a_idx, b_idx;
    logic [MOD_W-1:0]       sub_c, a_wide, b_wide;

    assign a_ext  = {{VW{1'b0}}, a_reg};
    assign b_ext  = {{VW{1'b0}}, b_reg};
    assign a_idx  = a_ext[VW-1:0];
    assign b_idx  = b_ext[VW-1:0];
    assign ra_ext = {{VERTEX_W{1'b0}}, root_a_reg};
    assign rb_ext = {{VERTEX_W{1'b0}}, cur_reg};

    assign sub_c  = MOD_C << k_reg;
    assign a_wide = {1'b0, a_reg};
    assign b_wide = {1'b0, b_reg};

    assign rd_root   = ram_rdata[VW];
    assign rd_parent = ram_rdata[VW-1:0];

    // in DONE cur_reg holds the root of the second endpoint
    assign closes  = (root_a_reg == cur_reg);
    assign done_go = !m_valid_reg || m_ready;

    ufcd_ram #(
        .WIDTH (VW + 1),
        .DEPTH (MAX_VERTICES)
    ) u_parent_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (RED_STEPS > 0) ? ST_REDUCE : ST_START;
                end
            end
            ST_REDUCE: begin
                if (k_reg == '0) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_FIND_A;
            ST_FIND_A: begin
                if (rd_root) begin
                    state_next = ST_FIND_B;
                end
            end
            ST_FIND_B: begin
                if (rd_root) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = {1'b1, {VW{1'b0}}};
        ram_raddr = cur_reg;
        unique case (state_reg)
            ST_CLEAR: ram_we = 1'b1;
            ST_IDLE:  s_ready = 1'b1;
            ST_START: ram_raddr = a_idx;
            ST_FIND_A: begin
                ram_raddr = rd_root ? b_idx : rd_parent;
            end
            ST_FIND_B: ram_raddr = rd_parent;
            ST_DONE: begin
                ram_we    = done_go && !closes;
                ram_waddr = root_a_reg;
                ram_wdata = {1'b0, cur_reg};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cycle_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && done_go) begin
                m_valid_reg <= 1'b1;
                cycle_reg   <= cycle_reg | closes;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                a_reg <= s_data.from_vertex;
                b_reg <= s_data.to_vertex;
                k_reg <= K_FIRST;
            end
            ST_REDUCE: begin
                if (a_wide >= sub_c) begin
                    a_reg <= VERTEX_W'(a_wide - sub_c);
                end
                if (b_wide >= sub_c) begin
                    b_reg <= VERTEX_W'(b_wide - sub_c);
                end
                k_reg <= k_reg - 1'b1;
            end
            ST_START: cur_reg <= a_idx;
            ST_FIND_A: begin
                if (rd_root) begin
                    root_a_reg <= cur_reg;
                    cur_reg    <= b_idx;
                end else begin
                    cur_reg <= rd_parent;
                end
            end
            ST_FIND_B: begin
                if (!rd_root) begin
                    cur_reg <= rd_parent;
                end
            end
            ST_DONE: begin
                if (done_go) begin
                    m_data_reg.closes_cycle <= closes;
                    m_data_reg.cycle_seen   <= cycle_reg | closes;
                    m_data_reg.from_root    <= ra_ext[VERTEX_W-1:0];
                    m_data_reg.to_root      <= rb_ext[VERTEX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a link is only ever written between two distinct roots
    a_link_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_DONE) |-> (root_a_reg != cur_reg))
        else $error("link written between equal roots");

    // a cycle result always carries the sticky flag
    a_cycle_sticky_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.closes_cycle) |-> m_data.cycle_seen)
        else $error("closes_cycle without cycle_seen");

    // the sticky flag never drops outside reset
    a_cycle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cycle_reg |=> cycle_reg)
        else $error("cycle flag dropped");

    // no edge is taken while the clearing pass runs
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("edge accepted during clearing pass");

endmodule

[test/union_find_cycle_detector_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_detector_unit_tb
// Drives edges into the cycle detector and checks every result against a
// parent-forest predictor kept in the testbench. A directed opening covers
// the field extremes, self loops, long chains and repeated closures. Random
// rings, local clusters, self loops and wide edges follow. The sender works
// in bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module union_find_cycle_detector_unit_tb;
    import ufcd_pkg::*;

    localparam int MAX_VERTICES = MAX_VERTICES_DEF;
    localparam int N_RANDOM     = 1530;
    localparam int MAX_GAP      = 8;
    localparam int MAX_STALL    = 24;
    localparam int WINDOW       = 32;
    localparam int TAIL_CYCLES  = 64;
    localparam int LIMIT        = 3 * (N_RANDOM + 25)
                                  * (2 * MAX_VERTICES + 5 + MAX_GAP + MAX_STALL)
                                  + MAX_VERTICES;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

    // ------------------------------------------------------------------------
    // Forest predictor and store of due verdicts
    // ------------------------------------------------------------------------
    class forest_scoreboard;
        bit           is_root [MAX_VERTICES];
        int unsigned  up_link [MAX_VERTICES];
        bit           cycle_latched;
        ufcd_result_t verdicts_due [$];
        int unsigned  faults;
        int unsigned  edges_noted;
        int unsigned  verdicts_checked;
        int unsigned  closures;
        int unsigned  longest_walk;

        function new();
            for (int i = 0; i < MAX_VERTICES; i++) begin
                is_root[i] = 1'b1;
                up_link[i] = 0;
            end
            cycle_latched    = 1'b0;
            faults           = 0;
            edges_noted      = 0;
            verdicts_checked = 0;
            closures         = 0;
            longest_walk     = 0;
        endfunction

        function int unsigned root_of(int unsigned v);
            int unsigned cur;
            int unsigned steps;
            cur   = v % MAX_VERTICES;
            steps = 0;
            while (!is_root[cur] && steps < MAX_VERTICES) begin
                cur = up_link[cur] % MAX_VERTICES;
                steps++;
            end
            if (steps > longest_walk) begin
                longest_walk = steps;
            end
            return cur;
        endfunction

        function void note_edge(ufcd_edge_t e);
            ufcd_result_t v;
            int unsigned  ra;
            int unsigned  rb;
            ra = root_of(e.from_vertex);
            rb = root_of(e.to_vertex);
            v.closes_cycle = (ra == rb);
            if (ra == rb) begin
                cycle_latched = 1'b1;
                closures++;
            end else begin
                // link the first root under the second
                is_root[ra] = 1'b0;
                up_link[ra] = rb;
            end
            v.cycle_seen = cycle_latched;
            v.from_root  = ra[VERTEX_W-1:0];
            v.to_root    = rb[VERTEX_W-1:0];
            verdicts_due = {verdicts_due, v};
            edges_noted++;
        endfunction

        function void check_verdict(ufcd_result_t got);
            ufcd_result_t want;
            if (verdicts_due.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: result word with nothing due: cyc=%0b seen=%0b fr=%0d tr=%0d",
                             $time, got.closes_cycle, got.cycle_seen, got.from_root,
                             got.to_root);
                end
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (got.closes_cycle !== want.closes_cycle || got.cycle_seen !== want.cycle_seen
                    || got.from_root !== want.from_root || got.to_root !== want.to_root) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: result %0d mismatch: want cyc=%0b seen=%0b fr=%0d tr=%0d",
                             $time, verdicts_checked, want.closes_cycle, want.cycle_seen,
                             want.from_root, want.to_root);
                    $display("%0t: result %0d mismatch: got  cyc=%0b seen=%0b fr=%0d tr=%0d",
                             $time, verdicts_checked, got.closes_cycle, got.cycle_seen,
                             got.from_root, got.to_root);
                end
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------------
    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    ufcd_edge_t   s_data  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    ufcd_result_t m_data;

    forest_scoreboard sb = new();

    int unsigned  cycle_count = 0;
    int unsigned  burst_left  = 0;
    int unsigned  window_base = 0;
    ufcd_edge_t   edge_stash [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    union_find_cycle_detector_unit #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("union_find_cycle_detector_unit_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, stall on a changing pattern
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_verdict(m_data);
        end
    end

    rx_mode_t    rx_mode    = RX_OPEN;
    int unsigned rx_phase   = 0;
    int unsigned stall_left = 0;

    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 256 == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= (rx_phase % 4 == 3);
            default: begin
                if (stall_left > 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left <= $urandom_range(1, MAX_STALL);
                    end
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Edge side
    // ------------------------------------------------------------------------
    task automatic hold_off(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_edge(input ufcd_edge_t e);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_edge(e);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_off($urandom_range(1, MAX_GAP));
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // hold the sender until every due result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic void stash(input int unsigned a, input int unsigned b);
        ufcd_edge_t e;
        e.from_vertex = a[VERTEX_W-1:0];
        e.to_vertex   = b[VERTEX_W-1:0];
        edge_stash = {edge_stash, e};
    endfunction

    function automatic int unsigned pick_vertex(input bit near);
        if (near) begin
            return window_base + $urandom_range(0, WINDOW - 1);
        end
        return $urandom_range(0, MAX_VERTICES - 1);
    endfunction

    function automatic void fill_stash();
        int unsigned roll;
        int unsigned k;
        int unsigned v;
        int unsigned ring [$];
        bit          near;
        if ($urandom_range(0, 31) == 0) begin
            window_base = $urandom_range(0, MAX_VERTICES - WINDOW);
        end
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            // chain through k vertices, then close it back to the start
            k    = $urandom_range(2, 7);
            near = 1'($urandom_range(0, 1));
            for (int i = 0; i < k; i++) begin
                ring = {ring, pick_vertex(near)};
            end
            for (int i = 0; i + 1 < k; i++) begin
                stash(ring[i], ring[i + 1]);
            end
            stash(ring[k - 1], ring[0]);
        end else if (roll < 7) begin
            stash(pick_vertex(1'b1), pick_vertex(1'b1));
        end else if (roll == 7) begin
            v = pick_vertex(1'($urandom_range(0, 1)));
            stash(v, v);
        end else begin
            stash(pick_vertex(1'b0), pick_vertex(1'b0));
        end
    endfunction

    initial begin
        int unsigned random_sent;
        random_sent = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening: extremes, a long chain, self loops, closures
        stash(0, MAX_VERTICES - 1);
        stash(MAX_VERTICES - 1, 1);
        for (int v = 2; v <= 12; v++) begin
            stash(v, v + 1);
        end
        stash(2, 13);
        stash(0, 1);
        stash(512, 512);
        stash(MAX_VERTICES - 1, MAX_VERTICES - 1);
        stash('h155, 'h2AA);
        stash('h2AA, 'h155);
        stash(MAX_VERTICES - 1, 2);
        stash(0, 12);
        while (edge_stash.size() != 0) begin
            send_edge(edge_stash.pop_front());
        end
        wait_drained();

        while (random_sent < N_RANDOM) begin
            if (edge_stash.size() == 0) begin
                fill_stash();
            end
            send_edge(edge_stash.pop_front());
            random_sent++;
            if (random_sent % 400 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d edges and %0d result words, %0d of them closing a cycle",
                 sb.edges_noted, sb.verdicts_checked, sb.closures);
        $display("deepest root walk %0d steps, %0d faults, %0d cycles",
                 sb.longest_walk, sb.faults + sb.pending(), cycle_count);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("union_find_cycle_detector_unit_tb: clean");
        end else begin
            $display("union_find_cycle_detector_unit_tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
src/ufcd_pkg.sv
src/ufcd_ram.sv
src/union_find_cycle_detector_unit.sv
test/union_find_cycle_detector_unit_tb.sv
